// ----- hw/rtl/mcd_pkg.sv -----
// Package for the MIDI clock divider: codes, register indexes, reset values
// and the structs passed between modules. No dependencies.
package mcd_pkg;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_MIDI = 2'd1,
		MODE_EXT  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CMD_MIDI_TICK = 2'd0,
		CMD_EXT_EDGE  = 2'd1,
		CMD_MS_TICK   = 2'd2,
		CMD_SELECT    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_DIVIDE_SELECT = 2'd0,
		REG_SILENCE_TIMEOUT = 2'd1,
		REG_PULSE_HIGH = 2'd2,
		REG_INVERT_OUTPUT = 2'd3
	} reg_idx_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [7:0] MIDI_BASE_DIV = 8'd12;
	// Largest divide select whose divisor still fits the counters.
	localparam logic [2:0] DIV_SEL_MAX = 3'd4;
	localparam logic [7:0] PULSE_MS_MAX = 8'hFF;
	localparam logic [15:0] SILENCE_MS_MAX = 16'hFFFF;

	localparam logic [2:0]  RST_DIVIDE_SELECT = 3'd1;
	localparam logic [15:0] RST_SILENCE_TIMEOUT = 16'd1000;
	localparam logic [7:0]  RST_PULSE_HIGH = 8'd10;
	localparam logic        RST_INVERT_OUTPUT = 1'b0;

	typedef struct packed {
		logic [2:0]  divide_select;
		logic [15:0] silence_timeout_ms;
		logic [7:0]  pulse_high_ms;
		logic        invert_output;
	} cfg_t;

	typedef struct packed {
		logic  clock_level;
		logic  pin_driven;
		logic  div_tick;
		mode_t source_mode;
	} result_t;

endpackage

// ----- hw/rtl/mcd_ifs.sv -----
// Valid/ready channel interfaces of the MIDI clock divider: item, result
// and configuration write. Depends on mcd_pkg.
interface mcd_item_if import mcd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [1:0] new_source;

	modport source (output valid, cmd, new_source, input ready);
	modport sink (input valid, cmd, new_source, output ready);
endinterface

interface mcd_result_if import mcd_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       clock_level;
	logic       pin_driven;
	logic       div_tick;
	logic [1:0] source_mode;

	modport source (output valid, clock_level, pin_driven, div_tick, source_mode,
		input ready);
	modport sink (input valid, clock_level, pin_driven, div_tick, source_mode,
		output ready);
endinterface

interface mcd_cfg_if import mcd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/midi_clock_divider_top.sv -----
// Channel   Role     Payload
// item      sink     cmd, new_source
// result    source   clock_level, pin_driven, div_tick, source_mode
// cfg       sink     index, data (always ready)
//
// Each item passes through the input register, then the output register, on
// its way to the result. The divider state updates as the item moves from the
// input register into the output register, so one item per cycle is sustained
// unless the result stalls. A stalled result holds both registers full and
// drops item.ready. arst_n clears the divider state and the valid flags.
// Depends on mcd_pkg, mcd_ifs, mcd_cfg_regs and mcd_core.
module midi_clock_divider_top import mcd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	mcd_item_if.sink      item,
	mcd_result_if.source  result,
	mcd_cfg_if.sink       cfg
);

	cfg_t       cfg_regs;
	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [1:0] src_s1;
	logic       out_valid_q;
	result_t    res_q;
	result_t    core_result;
	logic       advance;

	mcd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cfg_regs (cfg_regs)
	);

	mcd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_regs   (cfg_regs),
		.fire       (advance),
		.cmd        (cmd_s1),
		.new_source (src_s1),
		.result     (core_result)
	);

	// The item in stage one moves on whenever the output register is free
	// or its transaction completes in this cycle.
	assign advance = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			cmd_s1 <= item.cmd;
			src_s1 <= item.new_source;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_result;
		end
	end

	assign result.valid = out_valid_q;
	assign result.clock_level = res_q.clock_level;
	assign result.pin_driven = res_q.pin_driven;
	assign result.div_tick = res_q.div_tick;
	assign result.source_mode = res_q.source_mode;

endmodule

// ----- hw/rtl/mcd_cfg_regs.sv -----
// Configuration register file of the MIDI clock divider.
// Depends on mcd_pkg and mcd_cfg_if.
module mcd_cfg_regs import mcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mcd_cfg_if.sink   cfg,
	output cfg_t      cfg_regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign cfg_regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.divide_select <= RST_DIVIDE_SELECT;
			regs_q.silence_timeout_ms <= RST_SILENCE_TIMEOUT;
			regs_q.pulse_high_ms <= RST_PULSE_HIGH;
			regs_q.invert_output <= RST_INVERT_OUTPUT;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_DIVIDE_SELECT: regs_q.divide_select <= cfg.data[2:0];
				REG_SILENCE_TIMEOUT: regs_q.silence_timeout_ms <= cfg.data;
				REG_PULSE_HIGH: regs_q.pulse_high_ms <= cfg.data[7:0];
				REG_INVERT_OUTPUT: regs_q.invert_output <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

// ----- hw/rtl/mcd_core.sv -----
// Divider state and next-state logic: one command is applied per fire strobe
// and the result is formed from the updated state. Depends on mcd_pkg.
module mcd_core import mcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg_regs,
	input  logic       fire,
	input  logic [1:0] cmd,
	input  logic [1:0] new_source,
	output result_t    result
);

	mode_t       mode_q, mode_n;
	logic [7:0]  midi_count_q, midi_count_n;
	logic [4:0]  edge_count_q, edge_count_n;
	logic [15:0] silence_ms_q, silence_ms_n;
	logic [7:0]  pulse_ms_q, pulse_ms_n;
	logic        pulse_active_q, pulse_active_n;
	logic        event_n;

	logic [7:0]  midi_inc;
	logic [7:0]  midi_limit;
	logic [4:0]  edge_inc;
	logic [4:0]  edge_limit;
	logic [15:0] silence_inc;
	logic [7:0]  pulse_inc;
	logic        div_in_range;

	assign div_in_range = (cfg_regs.divide_select <= DIV_SEL_MAX);
	assign midi_limit = MIDI_BASE_DIV << cfg_regs.divide_select;
	assign edge_limit = 5'd1 << cfg_regs.divide_select;
	assign edge_inc = edge_count_q + 5'd1;
	assign silence_inc = (silence_ms_q == SILENCE_MS_MAX) ? silence_ms_q
		: silence_ms_q + 16'd1;
	assign pulse_inc = (pulse_ms_q == PULSE_MS_MAX) ? pulse_ms_q : pulse_ms_q + 8'd1;

	always_comb begin
		mode_n = mode_q;
		midi_count_n = midi_count_q;
		edge_count_n = edge_count_q;
		silence_ms_n = silence_ms_q;
		pulse_ms_n = pulse_ms_q;
		pulse_active_n = pulse_active_q;
		event_n = 1'b0;
		midi_inc = midi_count_q + 8'd1;

		case (cmd_t'(cmd))
			CMD_MIDI_TICK: begin
				if (mode_q != MODE_OFF) begin
					// A MIDI tick in external mode takes the block back to MIDI;
					// the divider count carries over.
					if (mode_q == MODE_EXT) begin
						mode_n = MODE_MIDI;
						pulse_active_n = 1'b0;
						pulse_ms_n = 8'd0;
					end
					silence_ms_n = 16'd0;
					if (div_in_range && midi_inc >= midi_limit) begin
						midi_inc = 8'd0;
					end
					midi_count_n = midi_inc;
					if (midi_inc == 8'd0) begin
						event_n = 1'b1;
						pulse_active_n = 1'b1;
						pulse_ms_n = 8'd0;
					end
				end
			end
			CMD_EXT_EDGE: begin
				if (mode_q == MODE_EXT) begin
					if (div_in_range && edge_inc >= edge_limit) begin
						edge_count_n = 5'd0;
					end else begin
						edge_count_n = edge_inc;
					end
					event_n = (edge_count_n == 5'd0);
				end
			end
			CMD_MS_TICK: begin
				if (mode_q == MODE_MIDI) begin
					if (silence_inc > cfg_regs.silence_timeout_ms) begin
						// Fallback to external keeps the pin level.
						silence_ms_n = 16'd0;
						mode_n = MODE_EXT;
						midi_count_n = 8'd0;
						pulse_ms_n = 8'd0;
					end else begin
						silence_ms_n = silence_inc;
						if (pulse_active_q) begin
							if (pulse_inc >= cfg_regs.pulse_high_ms) begin
								pulse_active_n = 1'b0;
								pulse_ms_n = 8'd0;
							end else begin
								pulse_ms_n = pulse_inc;
							end
						end
					end
				end
			end
			CMD_SELECT: begin
				if (new_source inside {MODE_OFF, MODE_MIDI, MODE_EXT} &&
					new_source != mode_q) begin
					mode_n = mode_t'(new_source);
					pulse_ms_n = 8'd0;
					case (mode_t'(new_source))
						MODE_MIDI: begin
							pulse_active_n = 1'b0;
							silence_ms_n = 16'd0;
						end
						MODE_EXT: midi_count_n = 8'd0;
						default: begin
							pulse_active_n = 1'b0;
							midi_count_n = 8'd0;
						end
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			midi_count_q <= 8'd0;
			edge_count_q <= 5'd0;
			silence_ms_q <= 16'd0;
			pulse_ms_q <= 8'd0;
			pulse_active_q <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_n;
			midi_count_q <= midi_count_n;
			edge_count_q <= edge_count_n;
			silence_ms_q <= silence_ms_n;
			pulse_ms_q <= pulse_ms_n;
			pulse_active_q <= pulse_active_n;
		end
	end

	assign result.clock_level = pulse_active_n ^ cfg_regs.invert_output;
	assign result.pin_driven = (mode_n == MODE_MIDI);
	assign result.div_tick = event_n;
	assign result.source_mode = mode_n;

endmodule

// ----- tb/mcd_divider_checker.sv -----
// Scoreboard for the MIDI clock divider: follows the configuration, item and
// result channels, predicts every result and compares it field by field.
// Depends on mcd_pkg and mcd_ifs.
module mcd_divider_checker import mcd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	mcd_item_if   item,
	mcd_result_if result,
	mcd_cfg_if    cfg,
	output int    fails,
	output int    pending,
	output int    checked,
	output int    tick_total
);

	// Copy of the configuration registers.
	logic [2:0]  div_sel;
	logic [15:0] quiet_limit;
	logic [7:0]  pulse_len;
	logic        invert;

	// Copy of the divider state.
	mode_t       cur_mode;
	logic [7:0]  midi_cnt;
	logic [4:0]  edge_cnt;
	logic [15:0] quiet_ms;
	logic [7:0]  pulse_age;
	logic        pulse_on;

	result_t     want_q[$];
	result_t     want;

	task automatic note_mismatch(string what);
		$display("MISMATCH at result %0d: %s", checked, what);
		fails++;
	endtask

	function automatic void switch_source(mode_t m);
		if (m != cur_mode) begin
			case (m)
			MODE_MIDI: begin
				pulse_on = 1'b0;
				quiet_ms = '0;
			end
			MODE_EXT: begin
				midi_cnt = '0;
			end
			default: begin
				pulse_on = 1'b0;
				midi_cnt = '0;
			end
			endcase
			pulse_age = '0;
			cur_mode = m;
		end
	endfunction

	function automatic result_t advance_divider(cmd_t c, logic [1:0] src);
		result_t     r;
		int unsigned span;
		logic        fired;
		fired = 1'b0;
		case (c)
		CMD_MIDI_TICK: begin
			if (cur_mode != MODE_OFF) begin
				// For large selects the divisor exceeds the counter, which then wraps.
				span = 32'(MIDI_BASE_DIV) << div_sel;
				if (cur_mode == MODE_EXT)
					switch_source(MODE_MIDI);
				quiet_ms = '0;
				midi_cnt = midi_cnt + 8'd1;
				if (32'(midi_cnt) >= span)
					midi_cnt = '0;
				if (midi_cnt == 8'd0) begin
					fired = 1'b1;
					pulse_on = 1'b1;
					pulse_age = '0;
				end
			end
		end
		CMD_EXT_EDGE: begin
			if (cur_mode == MODE_EXT) begin
				edge_cnt = edge_cnt + 5'd1;
				if (32'(edge_cnt) >= (32'd1 << div_sel))
					edge_cnt = '0;
				if (edge_cnt == 5'd0)
					fired = 1'b1;
			end
		end
		CMD_MS_TICK: begin
			if (cur_mode == MODE_MIDI) begin
				if (quiet_ms != SILENCE_MS_MAX)
					quiet_ms = quiet_ms + 16'd1;
				if (quiet_ms > quiet_limit) begin
					quiet_ms = '0;
					switch_source(MODE_EXT);
				end else if (pulse_on) begin
					if (pulse_age != PULSE_MS_MAX)
						pulse_age = pulse_age + 8'd1;
					if (pulse_age >= pulse_len) begin
						pulse_on = 1'b0;
						pulse_age = '0;
					end
				end
			end
		end
		default: begin
			if (src <= 2'(MODE_EXT))
				switch_source(mode_t'(src));
		end
		endcase
		r.clock_level = pulse_on ^ invert;
		r.pin_driven = (cur_mode == MODE_MIDI);
		r.div_tick = fired;
		r.source_mode = cur_mode;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_sel = RST_DIVIDE_SELECT;
			quiet_limit = RST_SILENCE_TIMEOUT;
			pulse_len = RST_PULSE_HIGH;
			invert = RST_INVERT_OUTPUT;
			cur_mode = MODE_OFF;
			midi_cnt = '0;
			edge_cnt = '0;
			quiet_ms = '0;
			pulse_age = '0;
			pulse_on = 1'b0;
			want_q.delete();
			fails = 0;
			pending = 0;
			checked = 0;
			tick_total = 0;
		end else begin
			if (result.valid && result.ready) begin
				if (want_q.size() == 0) begin
					note_mismatch("result transaction with no command waiting for it");
				end else begin
					want = want_q.pop_front();
					if (result.clock_level !== want.clock_level)
						note_mismatch($sformatf("clock_level got %b want %b",
							result.clock_level, want.clock_level));
					if (result.pin_driven !== want.pin_driven)
						note_mismatch($sformatf("pin_driven got %b want %b",
							result.pin_driven, want.pin_driven));
					if (result.div_tick !== want.div_tick)
						note_mismatch($sformatf("div_tick got %b want %b",
							result.div_tick, want.div_tick));
					if (result.source_mode !== want.source_mode)
						note_mismatch($sformatf("source_mode got %0d want %0d",
							result.source_mode, want.source_mode));
					if (want.div_tick)
						tick_total++;
					checked++;
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
				REG_DIVIDE_SELECT: div_sel = cfg.data[2:0];
				REG_SILENCE_TIMEOUT: quiet_limit = cfg.data;
				REG_PULSE_HIGH: pulse_len = cfg.data[7:0];
				default: invert = cfg.data[0];
				endcase
			end
			if (item.valid && item.ready)
				want_q.push_back(advance_divider(cmd_t'(item.cmd), item.new_source));
			pending = want_q.size();
		end
	end

endmodule

// ----- tb/midi_clock_divider_top_test.sv -----
// Testbench top for the MIDI clock divider: clock, reset, stimulus on the
// item and configuration channels, result back-pressure and the verdict.
// Depends on mcd_pkg, mcd_ifs, midi_clock_divider_top and mcd_divider_checker.
module midi_clock_divider_top_test;
	import mcd_pkg::*;

	localparam int         STALL_LIMIT = 300;
	localparam logic [1:0] SRC_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   gap_pct = 0;
	int   stall_left = 0;
	int   quiet_cycles = 0;
	int   items_sent = 0;
	int   settings = 0;
	int   fails;
	int   pending;
	int   checked;
	int   tick_total;

	mcd_item_if   item_ch ();
	mcd_result_if result_ch ();
	mcd_cfg_if    cfg_ch ();

	midi_clock_divider_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	mcd_divider_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.fails      (fails),
		.pending    (pending),
		.checked    (checked),
		.tick_total (tick_total)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result back-pressure: ready is dropped for bursts of random length.
	always @(negedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			result_ch.ready <= 1'b1;
		end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct / 2) begin
			result_ch.ready <= 1'b0;
			stall_left <= $urandom_range(1, 7);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) ||
				(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Every task below starts and ends just after a falling edge. Valid is left
	// high between back-to-back commands so it never drops and rises in one step.
	task automatic send_item(cmd_t c, logic [1:0] src);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd <= c;
		item_ch.new_source <= src;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_run(cmd_t c, int n);
		repeat (n) send_item(c, 2'($urandom_range(0, 3)));
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic apply_setting(logic [2:0] div, logic [15:0] tmo, logic [7:0] plen,
			logic inv);
		logic [15:0] vals [4];
		drain();
		vals[REG_DIVIDE_SELECT] = {13'd0, div};
		vals[REG_SILENCE_TIMEOUT] = tmo;
		vals[REG_PULSE_HIGH] = {8'd0, plen};
		vals[REG_INVERT_OUTPUT] = {15'd0, inv};
		cfg_ch.valid <= 1'b1;
		for (int i = REG_DIVIDE_SELECT; i <= REG_INVERT_OUTPUT; i++) begin
			cfg_ch.index <= reg_idx_t'(i);
			cfg_ch.data <= vals[i];
			do @(posedge clk); while (!cfg_ch.ready);
			@(negedge clk);
		end
		cfg_ch.valid <= 1'b0;
		settings++;
	endtask

	// Mostly runs of one command kind or of mixed MIDI and ms ticks, so the dividers
	// wrap, pulses expire and the silence timeout fires; selects, drains and odd single commands are mixed in.
	task automatic random_phase(int n_items);
		int first;
		int pick;
		int len;
		first = items_sent;
		while (items_sent - first < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				send_item(CMD_SELECT, ($urandom_range(0, 1) == 0) ? 2'(MODE_MIDI) :
					2'($urandom_range(0, 3)));
			end else if (pick < 10) begin
				drain();
			end else if (pick < 30) begin
				send_run(CMD_MS_TICK, $urandom_range(1, 40));
			end else if (pick < 42) begin
				send_run(CMD_EXT_EDGE, $urandom_range(1, 40));
			end else if (pick < 65) begin
				send_run(CMD_MIDI_TICK, $urandom_range(1, 50));
			end else if (pick < 92) begin
				len = $urandom_range(1, 60);
				repeat (len)
					send_item(($urandom_range(0, 2) == 0) ? CMD_MS_TICK : CMD_MIDI_TICK,
						2'($urandom_range(0, 3)));
			end else begin
				send_item(cmd_t'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.cmd = CMD_MIDI_TICK;
		item_ch.new_source = 2'(MODE_OFF);
		result_ch.ready = 1'b1;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_DIVIDE_SELECT;
		cfg_ch.data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed pass under the reset configuration: commands ignored while off,
		// selects of the current mode and of the unused source value, and several
		// mode changes.
		send_item(CMD_MS_TICK, SRC_UNUSED);
		send_item(CMD_MIDI_TICK, SRC_UNUSED);
		send_item(CMD_EXT_EDGE, 2'(MODE_OFF));
		send_item(CMD_SELECT, SRC_UNUSED);
		send_item(CMD_SELECT, 2'(MODE_OFF));
		send_item(CMD_SELECT, 2'(MODE_EXT));
		send_item(CMD_EXT_EDGE, SRC_UNUSED);
		send_item(CMD_EXT_EDGE, 2'(MODE_OFF));
		send_item(CMD_MS_TICK, 2'(MODE_MIDI));
		send_item(CMD_MIDI_TICK, 2'(MODE_OFF));
		send_item(CMD_SELECT, 2'(MODE_MIDI));
		send_item(CMD_EXT_EDGE, 2'(MODE_EXT));
		send_item(CMD_MS_TICK, SRC_UNUSED);
		send_item(CMD_SELECT, 2'(MODE_EXT));
		send_item(CMD_SELECT, 2'(MODE_OFF));
		send_item(CMD_SELECT, 2'(MODE_MIDI));
		send_item(CMD_MIDI_TICK, SRC_UNUSED);

		gap_pct = 15;
		apply_setting(3'd0, 16'd0, 8'd0, 1'b1);
		random_phase(90);

		// Largest settings: one 256-tick MIDI period, then a 255 ms pulse that
		// runs out well before the silence timeout could fire.
		gap_pct = 10;
		apply_setting(3'd7, 16'hFFFF, 8'hFF, 1'b0);
		send_item(CMD_SELECT, 2'(MODE_MIDI));
		send_run(CMD_MIDI_TICK, 256);
		send_run(CMD_MS_TICK, 260);
		random_phase(50);

		gap_pct = 40;
		apply_setting(3'd4, 16'd30, 8'd3, 1'b1);
		random_phase(90);

		gap_pct = 0;
		apply_setting(3'd5, 16'd1, 8'd1, 1'b0);
		random_phase(90);

		gap_pct = 15;
		apply_setting(RST_DIVIDE_SELECT, RST_SILENCE_TIMEOUT, RST_PULSE_HIGH,
			RST_INVERT_OUTPUT);
		random_phase(90);

		repeat (2) begin
			gap_pct = ($urandom_range(0, 1) == 0) ? 15 : 40;
			apply_setting(3'($urandom_range(0, 7)), 16'($urandom_range(0, 50)),
				8'($urandom_range(0, 20)), 1'($urandom_range(0, 1)));
			random_phase(90);
		end

		gap_pct = 0;
		apply_setting(3'($urandom_range(0, 7)), 16'($urandom_range(0, 50)),
			8'($urandom_range(0, 20)), 1'($urandom_range(0, 1)));
		random_phase(50);

		drain();
		repeat (8) @(negedge clk);
		$display("Sent %0d commands under %0d register settings; %0d results compared,",
			items_sent, settings + 1, checked);
		$display("%0d of them carrying a divided clock event.", tick_total);
		if (fails == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", fails);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
